// ----- rtl/sahss_pkg.sv -----
// ----------------------------------------------------------------------------
// sahss_pkg: shared types and constants for the SAH split sweep
// Config layout, edge and result beats, queue entry and fixed widths.
// ----------------------------------------------------------------------------
package sahss_pkg;

  // Object count clamp
  localparam int unsigned MaxObjects = 1024;

  // Field widths
  localparam int unsigned CntW     = 11;
  localparam int unsigned PosW     = 32;
  localparam int unsigned ExtW     = 31;
  localparam int unsigned CostW    = 16;
  localparam int unsigned BonusW   = 9;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Datapath widths of the shared multiplier and accumulator
  localparam int unsigned MulW  = 33;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned AccW  = 104;

  // Full weight (no empty-side bonus), Q1.8
  localparam logic [BonusW-1:0] KFull = 9'd256;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLower     = 3'd0,
    CfgUpper     = 3'd1,
    CfgExtFirst  = 3'd2,
    CfgExtSecond = 3'd3,
    CfgTrav      = 3'd4,
    CfgIsect     = 3'd5,
    CfgBonus     = 3'd6,
    CfgObjects   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [PosW-1:0] lower_bound;
    logic signed [PosW-1:0] upper_bound;
    logic [ExtW-1:0]        extent_first;
    logic [ExtW-1:0]        extent_second;
    logic [CostW-1:0]       traversal_cost;
    logic [CostW-1:0]       intersect_cost;
    logic [BonusW-1:0]      empty_bonus;
    logic [CntW-1:0]        object_count;
  } cfg_t;

  typedef struct packed {
    logic signed [PosW-1:0] edge_position;
    logic                   edge_is_start;
    logic                   edge_last;
  } edge_t;

  typedef struct packed {
    logic            split_found;
    logic [CntW-1:0] split_index;
  } result_t;

  // Classified edge, as handed from front to back
  typedef struct packed {
    logic signed [PosW-1:0] pos;
    logic [CntW-1:0]        count_below;
    logic [CntW-1:0]        count_above;
    logic [CntW-1:0]        edge_index;
    logic                   in_node;
    logic                   empty;
    logic                   first;
    logic                   last;
  } q_entry_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } q_status_t;

  // Object count limited to MaxObjects
  function automatic logic [CntW-1:0] objects_eff(logic [CntW-1:0] n);
    logic [CntW-1:0] r;
    r = n;
    if (32'(n) > MaxObjects) r = CntW'(MaxObjects);
    return r;
  endfunction

endpackage

// ----- rtl/sahss_front.sv -----
// ----------------------------------------------------------------------------
// sahss_front: edge intake and classification
// Keeps the below/above/index counters, flags edges strictly inside the
// node interval and pushes one classified entry per accepted beat.
// ----------------------------------------------------------------------------
module sahss_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sahss_pkg::cfg_t     cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sahss_pkg::edge_t    in_data_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output sahss_pkg::q_entry_t q_data_o
);

  logic                       fresh_q;
  logic [sahss_pkg::CntW-1:0] below_q, above_q, index_q;
  logic [sahss_pkg::CntW-1:0] below_cur, above_cur, index_cur, above_new;
  logic                       accept;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign q_push_o   = accept;

  // Counters restart on the first edge of a sweep
  always_comb begin
    below_cur = fresh_q ? '0 : below_q;
    above_cur = fresh_q ? sahss_pkg::objects_eff(cfg_i.object_count) : above_q;
    index_cur = fresh_q ? '0 : index_q;
    above_new = in_data_i.edge_is_start ? above_cur : above_cur - 1'b1;
  end

  // Classified entry
  always_comb begin
    q_data_o.pos         = in_data_i.edge_position;
    q_data_o.count_below = below_cur;
    q_data_o.count_above = above_new;
    q_data_o.edge_index  = index_cur;
    q_data_o.in_node     = ($signed(in_data_i.edge_position) > $signed(cfg_i.lower_bound)) &&
                           ($signed(in_data_i.edge_position) < $signed(cfg_i.upper_bound));
    q_data_o.empty       = (below_cur == '0) || (above_new == '0);
    q_data_o.first       = fresh_q;
    q_data_o.last        = in_data_i.edge_last;
  end

  // Sweep counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
      below_q <= '0;
      above_q <= '0;
      index_q <= '0;
    end else if (accept) begin
      fresh_q <= in_data_i.edge_last;
      below_q <= below_cur + sahss_pkg::CntW'(in_data_i.edge_is_start);
      above_q <= above_new;
      index_q <= index_cur + 1'b1;
    end
  end

endmodule

// ----- rtl/sahss_queue.sv -----
// ----------------------------------------------------------------------------
// sahss_queue: short FIFO between front and back
// Lets the front keep taking edges while the back works on costs.
// ----------------------------------------------------------------------------
module sahss_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sahss_pkg::q_entry_t  push_data_i,
  input  logic                 pop_i,
  output sahss_pkg::q_entry_t  pop_data_o,
  output sahss_pkg::q_status_t status_o
);

  sahss_pkg::q_entry_t         mem_q [sahss_pkg::QueueDepth];
  logic [sahss_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [sahss_pkg::QCntW-1:0] count_q;

  localparam logic [sahss_pkg::QPtrW-1:0] LastPtr =
    sahss_pkg::QPtrW'(sahss_pkg::QueueDepth - 1);

  assign status_o.full  = (count_q == sahss_pkg::QCntW'(sahss_pkg::QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ----- rtl/sahss_back.sv -----
// ----------------------------------------------------------------------------
// sahss_back: SAH cost sequencer
// One 33x33 multiplier feeding a 104-bit shift-accumulator computes half
// area, leaf cost and split cost per edge; keeps the cheapest edge and
// drives the result register on the last edge.
// ----------------------------------------------------------------------------
module sahss_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sahss_pkg::cfg_t     cfg_i,
  input  logic                cfg_we_i,
  input  logic                q_empty_i,
  input  sahss_pkg::q_entry_t q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sahss_pkg::result_t  out_data_o
);

  localparam int unsigned MulW  = sahss_pkg::MulW;
  localparam int unsigned ProdW = sahss_pkg::ProdW;
  localparam int unsigned AccW  = sahss_pkg::AccW;
  localparam int unsigned CntW  = sahss_pkg::CntW;
  localparam int unsigned ShW   = 7;

  // Accumulator shift amounts
  localparam logic [ShW-1:0] ShNone   = ShW'(0);
  localparam logic [ShW-1:0] ShByte   = ShW'(8);
  localparam logic [ShW-1:0] ShChunk  = ShW'(MulW);
  localparam logic [ShW-1:0] ShChByte = ShW'(MulW + 8);
  localparam logic [ShW-1:0] ShTwoCh  = ShW'(2 * MulW);

  typedef enum logic [21:0] {
    StIdle = 22'h000001,
    StTAb  = 22'h000002,
    StTDz  = 22'h000004,
    StTCap = 22'h000008,
    StLIo  = 22'h000010,
    StLT0  = 22'h000020,
    StLT1  = 22'h000040,
    StLCap = 22'h000080,
    StCP0  = 22'h000100,
    StCP1  = 22'h000200,
    StCS0  = 22'h000400,
    StCS1  = 22'h000800,
    StCS2  = 22'h001000,
    StCS3  = 22'h002000,
    StCS4  = 22'h004000,
    StCS5  = 22'h008000,
    StCS6  = 22'h010000,
    StCS7  = 22'h020000,
    StCS8  = 22'h040000,
    StCS9  = 22'h080000,
    StCCmp = 22'h100000,
    StFin  = 22'h200000
  } back_state_e;

  back_state_e         state_q, state_d;
  sahss_pkg::q_entry_t item_q;

  logic              t_ok_q, t_ok_d;
  logic [65:0]       t_q;
  logic [61:0]       ab_q;
  logic [43:0]       p_q;
  logic [76:0]       s_q;
  logic [26:0]       w_q;
  logic [ProdW-1:0]  prod_q;
  logic [ShW-1:0]    sh_q;
  logic              add_q, clr_q;
  logic [AccW-1:0]   acc_q, acc_sum, best_q;
  logic [CntW-1:0]   best_edge_q, best_edge_d;
  logic              best_valid_q, best_valid_d;
  logic              out_valid_q, out_valid_d;
  sahss_pkg::result_t out_data_q;

  logic [MulW-1:0]   mul_a, mul_b;
  logic [ShW-1:0]    iss_sh;
  logic              iss_add, iss_clr;
  logic              out_load, cost_less;

  logic [31:0]       sa;
  logic [CntW:0]     nsum;
  logic [32:0]       dz_full, dl_full, du_full;
  logic [31:0]       dz;
  logic [sahss_pkg::BonusW-1:0] bonus, k;
  logic [CntW-1:0]   obj;

  // Operand prep
  always_comb begin
    sa      = {1'b0, cfg_i.extent_first} + {1'b0, cfg_i.extent_second};
    nsum    = {1'b0, item_q.count_below} + {1'b0, item_q.count_above};
    dz_full = {cfg_i.upper_bound[31], cfg_i.upper_bound} -
              {cfg_i.lower_bound[31], cfg_i.lower_bound};
    dz      = (!dz_full[32] && dz_full != '0) ? dz_full[31:0] : '0;
    dl_full = {item_q.pos[31], item_q.pos} - {cfg_i.lower_bound[31], cfg_i.lower_bound};
    du_full = {cfg_i.upper_bound[31], cfg_i.upper_bound} - {item_q.pos[31], item_q.pos};
    bonus   = (cfg_i.empty_bonus > sahss_pkg::KFull) ? sahss_pkg::KFull : cfg_i.empty_bonus;
    k       = item_q.empty ? sahss_pkg::KFull - bonus : sahss_pkg::KFull;
    obj     = sahss_pkg::objects_eff(cfg_i.object_count);
  end

  // Shift-accumulate of the registered product
  assign acc_sum   = (clr_q ? '0 : acc_q) + (AccW'(prod_q) << sh_q);
  assign cost_less = acc_sum < best_q;

  // Sequencer: operand issue and next state
  always_comb begin
    state_d  = state_q;
    mul_a    = '0;
    mul_b    = '0;
    iss_sh   = ShNone;
    iss_add  = 1'b0;
    iss_clr  = 1'b0;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      StIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (!t_ok_q)               state_d = StTAb;
          else if (q_data_i.first)   state_d = StLIo;
          else if (q_data_i.in_node) state_d = StCP0;
          else                       state_d = StFin;
        end
      end
      // Half area T = a*b + dz*(a+b)
      StTAb: begin
        mul_a = MulW'(cfg_i.extent_first);  mul_b = MulW'(cfg_i.extent_second);
        iss_add = 1'b1; iss_clr = 1'b1;
        state_d = StTDz;
      end
      StTDz: begin
        mul_a = MulW'(dz); mul_b = MulW'(sa);
        iss_add = 1'b1;
        state_d = StTCap;
      end
      StTCap: begin
        if (item_q.first)        state_d = StLIo;
        else if (item_q.in_node) state_d = StCP0;
        else                     state_d = StFin;
      end
      // Leaf cost = intersect*objects*T*256
      StLIo: begin
        mul_a = MulW'(cfg_i.intersect_cost); mul_b = MulW'(obj);
        state_d = StLT0;
      end
      StLT0: begin
        mul_a = MulW'(prod_q[26:0]); mul_b = t_q[32:0];
        iss_sh = ShByte; iss_add = 1'b1; iss_clr = 1'b1;
        state_d = StLT1;
      end
      StLT1: begin
        mul_a = MulW'(w_q); mul_b = t_q[65:33];
        iss_sh = ShChByte; iss_add = 1'b1;
        state_d = StLCap;
      end
      StLCap: begin
        state_d = item_q.in_node ? StCP0 : StFin;
      end
      // P = nb*dl + na*du
      StCP0: begin
        mul_a = MulW'(item_q.count_below); mul_b = MulW'(dl_full[31:0]);
        iss_add = 1'b1; iss_clr = 1'b1;
        state_d = StCP1;
      end
      StCP1: begin
        mul_a = MulW'(item_q.count_above); mul_b = MulW'(du_full[31:0]);
        iss_add = 1'b1;
        state_d = StCS0;
      end
      // Area sum = ab*(nb+na) + (a+b)*P
      StCS0: begin
        mul_a = ab_q[32:0]; mul_b = MulW'(nsum);
        iss_add = 1'b1; iss_clr = 1'b1;
        state_d = StCS1;
      end
      StCS1: begin
        mul_a = MulW'(ab_q[61:33]); mul_b = MulW'(nsum);
        iss_sh = ShChunk; iss_add = 1'b1;
        state_d = StCS2;
      end
      StCS2: begin
        mul_a = MulW'(sa); mul_b = p_q[32:0];
        iss_add = 1'b1;
        state_d = StCS3;
      end
      StCS3: begin
        mul_a = MulW'(sa); mul_b = MulW'(p_q[43:33]);
        iss_sh = ShChunk; iss_add = 1'b1;
        state_d = StCS4;
      end
      // Weight = intersect*k
      StCS4: begin
        mul_a = MulW'(cfg_i.intersect_cost); mul_b = MulW'(k);
        state_d = StCS5;
      end
      // Split cost = weight*sum + trav*T*256
      StCS5: begin
        mul_a = MulW'(prod_q[26:0]); mul_b = s_q[32:0];
        iss_add = 1'b1; iss_clr = 1'b1;
        state_d = StCS6;
      end
      StCS6: begin
        mul_a = MulW'(w_q); mul_b = s_q[65:33];
        iss_sh = ShChunk; iss_add = 1'b1;
        state_d = StCS7;
      end
      StCS7: begin
        mul_a = MulW'(w_q); mul_b = MulW'(s_q[76:66]);
        iss_sh = ShTwoCh; iss_add = 1'b1;
        state_d = StCS8;
      end
      StCS8: begin
        mul_a = MulW'(cfg_i.traversal_cost); mul_b = t_q[32:0];
        iss_sh = ShByte; iss_add = 1'b1;
        state_d = StCS9;
      end
      StCS9: begin
        mul_a = MulW'(cfg_i.traversal_cost); mul_b = t_q[65:33];
        iss_sh = ShChByte; iss_add = 1'b1;
        state_d = StCCmp;
      end
      StCCmp: begin
        state_d = StFin;
      end
      StFin: begin
        if (!item_q.last) begin
          state_d = StIdle;
        end else if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control next values
  always_comb begin
    t_ok_d       = t_ok_q;
    best_valid_d = best_valid_q;
    best_edge_d  = best_edge_q;
    if (state_q == StTCap) t_ok_d = 1'b1;
    if (cfg_we_i)          t_ok_d = 1'b0;
    if (state_q == StLCap) begin
      best_valid_d = 1'b0;
      best_edge_d  = '0;
    end
    if (state_q == StCCmp && cost_less) begin
      best_valid_d = 1'b1;
      best_edge_d  = item_q.edge_index;
    end
    out_valid_d = out_valid_q & ~out_ready_i;
    if (out_load) out_valid_d = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      t_ok_q       <= 1'b0;
      best_valid_q <= 1'b0;
      best_edge_q  <= '0;
      out_valid_q  <= 1'b0;
      add_q        <= 1'b0;
      clr_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      t_ok_q       <= t_ok_d;
      best_valid_q <= best_valid_d;
      best_edge_q  <= best_edge_d;
      out_valid_q  <= out_valid_d;
      add_q        <= iss_add;
      clr_q        <= iss_clr;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    sh_q   <= iss_sh;
    if (add_q) acc_q <= acc_sum;
    if (q_pop_o) item_q <= q_data_i;
    if (state_q == StTDz)  ab_q <= prod_q[61:0];
    if (state_q == StTCap) t_q  <= acc_sum[65:0];
    if (state_q == StLT0 || state_q == StCS5) w_q <= prod_q[26:0];
    if (state_q == StCS0) p_q <= acc_sum[43:0];
    if (state_q == StCS4) s_q <= acc_sum[76:0];
    if (state_q == StLCap || (state_q == StCCmp && cost_less)) best_q <= acc_sum;
    if (out_load) begin
      out_data_q.split_found <= best_valid_q;
      out_data_q.split_index <= best_valid_q ? best_edge_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/sah_split_sweep_core.sv -----
// ----------------------------------------------------------------------------
// sah_split_sweep_core: SAH kd-tree split sweep, top level
// Front takes one edge beat per cycle while the queue has room, into a
// 4-entry queue; the back steps each edge through states on one shared 33x33
// multiplier: split cost inside the node interval, plus leaf cost on a
// sweep's first edge and node area after a config write. The result register
// loads on the last edge once any old result is taken. Reset clears all
// control state and loads the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module sah_split_sweep_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sahss_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [sahss_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  sahss_pkg::edge_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sahss_pkg::result_t                out_data_o
);

  sahss_pkg::cfg_t      cfg_q;
  sahss_pkg::q_entry_t  push_data, pop_data;
  sahss_pkg::q_status_t q_status;
  logic                 push, pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lower_bound    <= '0;
      cfg_q.upper_bound    <= '0;
      cfg_q.extent_first   <= '0;
      cfg_q.extent_second  <= '0;
      cfg_q.traversal_cost <= 16'd256;
      cfg_q.intersect_cost <= 16'd20480;
      cfg_q.empty_bonus    <= 9'd128;
      cfg_q.object_count   <= 11'd1;
    end else if (cfg_we_i) begin
      case (sahss_pkg::cfg_idx_e'(cfg_index_i))
        sahss_pkg::CfgLower:     cfg_q.lower_bound    <= cfg_wdata_i;
        sahss_pkg::CfgUpper:     cfg_q.upper_bound    <= cfg_wdata_i;
        sahss_pkg::CfgExtFirst:  cfg_q.extent_first   <= cfg_wdata_i[30:0];
        sahss_pkg::CfgExtSecond: cfg_q.extent_second  <= cfg_wdata_i[30:0];
        sahss_pkg::CfgTrav:      cfg_q.traversal_cost <= cfg_wdata_i[15:0];
        sahss_pkg::CfgIsect:     cfg_q.intersect_cost <= cfg_wdata_i[15:0];
        sahss_pkg::CfgBonus:     cfg_q.empty_bonus    <= cfg_wdata_i[8:0];
        sahss_pkg::CfgObjects:   cfg_q.object_count   <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // Edge intake
  sahss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_status.full),
    .q_push_o   (push),
    .q_data_o   (push_data)
  );

  // Decoupling queue
  sahss_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  // Cost sequencer and result register
  sahss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_we_i    (cfg_we_i),
    .q_empty_i   (q_status.empty),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= sahss_pkg::QCntW'(sahss_pkg::QueueDepth))
    else $error("queue fill count above depth");

  // With the queue drained the front must take a beat
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.empty |-> in_ready_o)
    else $error("front stalled with empty queue");

  // No pop from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("back popped an empty queue");

endmodule

// ----- dv/sahss_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sahss_tb_pkg: split predictor and result checker for the SAH sweep bench
// Mirrors the sweep state per accepted edge beat in exact 128-bit integer
// cost math and checks each result beat in order against the expected split.
// ----------------------------------------------------------------------------
package sahss_tb_pkg;

  import sahss_pkg::*;

  typedef logic [127:0] cost_t;

  class split_predictor;

    // Node registers as last written
    logic signed [PosW-1:0] lower;
    logic signed [PosW-1:0] upper;
    logic [ExtW-1:0]        ext_a;
    logic [ExtW-1:0]        ext_b;
    logic [CostW-1:0]       trav;
    logic [CostW-1:0]       isect;
    logic [BonusW-1:0]      bonus;
    logic [CntW-1:0]        objects;

    // Running sweep state
    logic [CntW-1:0] n_below;
    logic [CntW-1:0] n_above;
    logic [CntW-1:0] edge_idx;
    logic [CntW-1:0] best_idx;
    cost_t           best_cost;
    bit              best_ok;
    bit              fresh;

    result_t     expected_splits[$];
    int unsigned mismatches;

    function new();
      lower      = '0;
      upper      = '0;
      ext_a      = '0;
      ext_b      = '0;
      trav       = 16'd256;
      isect      = 16'd20480;
      bonus      = 9'd128;
      objects    = 11'd1;
      mismatches = 0;
      begin_sweep();
      fresh = 1'b1;
    endfunction

    // Half the node surface area, in units of 2^-16 squared
    function cost_t area_sum();
      longint d;
      cost_t  dz;
      d  = longint'(upper) - longint'(lower);
      dz = (d > 0) ? cost_t'(d) : '0;
      return dz * cost_t'(ext_a) + dz * cost_t'(ext_b) + cost_t'(ext_a) * cost_t'(ext_b);
    endfunction

    // Reload counts and leaf cost from the registers in force now
    function void begin_sweep();
      logic [CntW-1:0] n;
      n = (objects > MaxObjects) ? CntW'(MaxObjects) : objects;
      n_below   = '0;
      n_above   = n;
      edge_idx  = '0;
      best_idx  = '0;
      best_ok   = 1'b0;
      best_cost = area_sum() * cost_t'(isect) * cost_t'(n) * 256;
      fresh     = 1'b0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        CfgLower:     lower   = v[PosW-1:0];
        CfgUpper:     upper   = v[PosW-1:0];
        CfgExtFirst:  ext_a   = v[ExtW-1:0];
        CfgExtSecond: ext_b   = v[ExtW-1:0];
        CfgTrav:      trav    = v[CostW-1:0];
        CfgIsect:     isect   = v[CostW-1:0];
        CfgBonus:     bonus   = v[BonusW-1:0];
        CfgObjects:   objects = v[CntW-1:0];
        default: ;
      endcase
    endfunction

    // Advance the sweep by one accepted edge beat
    function void note_edge(edge_t e);
      logic signed [PosW-1:0] pos;
      cost_t   ab_sum;
      cost_t   ab;
      cost_t   below;
      cost_t   above;
      cost_t   k;
      cost_t   cost;
      result_t want;
      pos = e.edge_position;
      if (fresh) begin
        begin_sweep();
      end
      if (!e.edge_is_start) begin
        n_above = n_above - 1'b1;
      end
      // only edges strictly inside the node interval are split candidates
      if (pos > lower && pos < upper) begin
        ab_sum = cost_t'(ext_a) + cost_t'(ext_b);
        ab     = cost_t'(ext_a) * cost_t'(ext_b);
        below  = ab + ab_sum * cost_t'(longint'(pos) - longint'(lower));
        above  = ab + ab_sum * cost_t'(longint'(upper) - longint'(pos));
        k      = cost_t'(KFull);
        if (n_below == '0 || n_above == '0) begin
          k = cost_t'(KFull) - cost_t'((bonus > KFull) ? KFull : bonus);
        end
        cost = area_sum() * cost_t'(trav) * 256
             + (below * cost_t'(n_below) + above * cost_t'(n_above)) * cost_t'(isect) * k;
        if (cost < best_cost) begin
          best_cost = cost;
          best_idx  = edge_idx;
          best_ok   = 1'b1;
        end
      end
      if (e.edge_is_start) begin
        n_below = n_below + 1'b1;
      end
      edge_idx = edge_idx + 1'b1;
      if (e.edge_last) begin
        want.split_found = best_ok;
        want.split_index = best_ok ? best_idx : '0;
        expected_splits = {expected_splits, want};
        fresh = 1'b1;
      end
    endfunction

    // Compare one accepted result beat with the oldest expected split
    function void check_split(result_t got);
      result_t want;
      if (expected_splits.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, actual found=%0d index=%0d",
                 $time, got.split_found, got.split_index);
        return;
      end
      want = expected_splits.pop_front();
      if (got.split_found !== want.split_found) begin
        mismatches++;
        $display("%0t: split_found mismatch, expected %0d, actual %0d",
                 $time, want.split_found, got.split_found);
      end
      if (got.split_index !== want.split_index) begin
        mismatches++;
        $display("%0t: split_index mismatch, expected %0d, actual %0d",
                 $time, want.split_index, got.split_index);
      end
    endfunction

    function int pending();
      return expected_splits.size();
    endfunction

  endclass

endpackage

// ----- dv/tb_sah_split_sweep_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sah_split_sweep_core: self-checking bench for the SAH split sweep core
// Streams directed then random edge sweeps under random stalls on both
// channels, reprograms the node registers between sweeps, and checks every
// result beat against a cycle-free predictor of the split choice.
// ----------------------------------------------------------------------------
module tb_sah_split_sweep_core;

  import sahss_pkg::*;
  import sahss_tb_pkg::*;

  localparam int unsigned RandomEdges  = 1050;
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned HoldCycles   = 2000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldSweeps   = 8;
  localparam longint      PosMin       = -64'sd2147483648;
  localparam longint      PosMax       = 64'sd2147483647;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  edge_t               in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  result_t             out_data;

  split_predictor sweep_model = new();

  int unsigned idle_pct   = 9;
  int unsigned edges_sent = 0;
  bit          hold_req   = 1'b0;

  always #10 clk_i = ~clk_i;

  sah_split_sweep_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // Run limit
  initial begin : watchdog
    int unsigned n;
    n = 0;
    while (n < CycleLimit) begin
      @(posedge clk_i);
      n++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Result beat monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      sweep_model.check_split(out_data);
    end
  end

  // Receiver: random stalls, plus one long hold-off to back up the core
  initial begin : receiver
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Offer one edge beat, with random gaps, and hold it until accepted
  task automatic send_edge(logic signed [PosW-1:0] pos, bit is_start, bit last);
    edge_t beat;
    beat.edge_position = pos;
    beat.edge_is_start = is_start;
    beat.edge_last     = last;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (!in_ready);
    sweep_model.note_edge(beat);
    edges_sent++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] v);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sweep_model.write_reg(idx, v);
  endtask

  // Stop offering, wait for all splits, then let the back end go quiet
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sweep_model.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Edge coordinate near the node interval: on a bound, just outside, or inside
  function automatic logic signed [PosW-1:0] pick_pos(longint lo, longint hi);
    longint      v;
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       v = lo;
      1:       v = hi;
      2:       v = lo - $urandom_range(1, 4096);
      3:       v = hi + $urandom_range(1, 4096);
      default: v = lo + longint'(r % (hi - lo + 1));
    endcase
    if (v < PosMin) v = PosMin;
    if (v > PosMax) v = PosMax;
    return v[PosW-1:0];
  endfunction

  function automatic logic [CfgDataW-1:0] pick_extent();
    logic [31:0] v;
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = 32'h7FFF_FFFF;
      default: v = $urandom >> $urandom_range(1, 31);
    endcase
    return {raw[31], v[30:0]};
  endfunction

  function automatic logic [CfgDataW-1:0] pick_cost();
    logic [15:0] v;
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = 16'hFFFF;
      default: v = $urandom_range(0, 65535) >> $urandom_range(0, 8);
    endcase
    return {raw[31:16], v};
  endfunction

  initial begin : stimulus
    longint                 lo_v;
    longint                 hi_v;
    longint                 lo_r;
    longint                 hi_r;
    logic signed [PosW-1:0] pos_list [32];
    bit                     start_list [32];
    logic signed [PosW-1:0] p1;
    logic signed [PosW-1:0] p2;
    logic signed [PosW-1:0] tp;
    bit                     ts;
    logic [31:0]            raw;
    logic [BonusW-1:0]      bv;
    logic [CntW-1:0]        nv;
    int                     n;
    int                     j;
    int                     len;
    int                     phase;
    int unsigned            base;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: zero-width node, nothing can lie inside
    send_edge(32'sh0, 1'b1, 1'b0);
    send_edge(32'sh0, 1'b0, 1'b1);
    drain();

    // Widest node and extents, zero traversal cost, masked upper data bits
    write_reg(CfgLower,     32'h8000_0000);
    write_reg(CfgUpper,     32'h7FFF_FFFF);
    write_reg(CfgExtFirst,  32'h7FFF_FFFF);
    write_reg(CfgExtSecond, 32'hFFFF_FFFF);
    write_reg(CfgTrav,      32'h0000_0000);
    write_reg(CfgIsect,     32'h0000_FFFF);
    write_reg(CfgBonus,     32'h0000_0000);
    write_reg(CfgObjects,   32'h0000_0002);
    send_edge(32'sh8000_0000, 1'b1, 1'b0);
    send_edge(32'sh0,         1'b1, 1'b0);
    send_edge(32'sh1,         1'b0, 1'b0);
    send_edge(32'sh7FFF_FFFF, 1'b0, 1'b1);
    drain();

    // Full empty-side bonus on a unit cube
    write_reg(CfgLower,     32'h0000_0000);
    write_reg(CfgUpper,     32'h0001_0000);
    write_reg(CfgExtFirst,  32'h0001_0000);
    write_reg(CfgExtSecond, 32'h0001_0000);
    write_reg(CfgTrav,      32'h0000_0064);
    write_reg(CfgBonus,     32'h0000_0100);
    write_reg(CfgObjects,   32'h0000_0001);
    send_edge(32'sh0000_8000, 1'b1, 1'b0);
    send_edge(32'sh0000_C000, 1'b0, 1'b1);
    drain();

    // Bonus above full scale, object count above the clamp
    write_reg(CfgBonus,   32'h0000_01FF);
    write_reg(CfgObjects, 32'h0000_07FF);
    send_edge(32'sh0000_4000, 1'b1, 1'b0);
    send_edge(32'sh0000_6000, 1'b0, 1'b1);
    drain();

    // Zero objects: end edges wrap the count above
    write_reg(CfgBonus,   32'h0000_0080);
    write_reg(CfgObjects, 32'h0000_0000);
    send_edge(32'sh0000_2000, 1'b0, 1'b0);
    send_edge(32'sh0000_3000, 1'b0, 1'b0);
    send_edge(32'sh0000_9000, 1'b1, 1'b1);
    drain();

    // Inverted bounds
    write_reg(CfgLower, 32'h0001_0000);
    write_reg(CfgUpper, 32'hFFFF_0000);
    send_edge(32'sh0,         1'b1, 1'b0);
    send_edge(32'sh0000_8000, 1'b0, 1'b1);
    drain();

    // Random phases: new registers, then a run of sweeps
    base  = edges_sent;
    phase = 0;
    while (edges_sent - base < RandomEdges) begin
      phase++;
      idle_pct = (phase == 3) ? 0 : 9;
      if (phase == 5) hold_req = 1'b1;

      // node bounds
      if ($urandom_range(9) < 8) begin
        case ($urandom_range(9))
          0: begin
            lo_v = PosMin;
            hi_v = PosMax;
          end
          1: begin
            lo_v = longint'($signed($urandom)) >>> $urandom_range(0, 16);
            hi_v = lo_v - $urandom_range(1, 1 << 20);
          end
          2: begin
            lo_v = longint'($signed($urandom)) >>> $urandom_range(0, 16);
            hi_v = lo_v;
          end
          default: begin
            lo_v = longint'($signed($urandom)) >>> $urandom_range(0, 16);
            hi_v = lo_v + ($urandom >> $urandom_range(0, 31));
          end
        endcase
        if (hi_v > PosMax) hi_v = PosMax;
        if (hi_v < PosMin) hi_v = PosMin;
        write_reg(CfgLower, lo_v[31:0]);
        write_reg(CfgUpper, hi_v[31:0]);
      end
      if ($urandom_range(9) < 7) write_reg(CfgExtFirst, pick_extent());
      if ($urandom_range(9) < 7) write_reg(CfgExtSecond, pick_extent());
      if ($urandom_range(9) < 7) write_reg(CfgTrav, pick_cost());
      if ($urandom_range(9) < 7) write_reg(CfgIsect, pick_cost());
      if ($urandom_range(9) < 7) begin
        raw = $urandom;
        case ($urandom_range(9))
          0:       bv = 9'd0;
          1:       bv = KFull;
          2:       bv = 9'd511;
          3:       bv = $urandom_range(257, 511);
          default: bv = $urandom_range(0, 256);
        endcase
        write_reg(CfgBonus, {raw[31:9], bv});
      end
      if ($urandom_range(9) < 7) begin
        raw = $urandom;
        case ($urandom_range(19))
          0:       nv = 11'd0;
          1:       nv = 11'd1024;
          2:       nv = $urandom_range(1025, 2047);
          3:       nv = 11'd2047;
          default: nv = $urandom_range(1, 12);
        endcase
        write_reg(CfgObjects, {raw[31:11], nv});
      end

      lo_r = (sweep_model.lower < sweep_model.upper) ? sweep_model.lower : sweep_model.upper;
      hi_r = (sweep_model.lower < sweep_model.upper) ? sweep_model.upper : sweep_model.lower;
      n    = sweep_model.objects;

      // the hold-off phase runs enough sweeps to back up the whole core
      repeat ((phase == 5) ? HoldSweeps : $urandom_range(2, 6)) begin
        if (n >= 1 && n <= 16 && $urandom_range(9) >= 2) begin
          // well-formed sweep: one start and one end edge per object, sorted
          for (int i = 0; i < n; i++) begin
            p1 = pick_pos(lo_r, hi_r);
            p2 = pick_pos(lo_r, hi_r);
            if (p2 < p1) begin
              tp = p1;
              p1 = p2;
              p2 = tp;
            end
            pos_list[2*i]     = p1;
            start_list[2*i]   = 1'b1;
            pos_list[2*i+1]   = p2;
            start_list[2*i+1] = 1'b0;
          end
          for (int i = 1; i < 2 * n; i++) begin
            tp = pos_list[i];
            ts = start_list[i];
            j  = i;
            while (j > 0 && pos_list[j-1] > tp) begin
              pos_list[j]   = pos_list[j-1];
              start_list[j] = start_list[j-1];
              j--;
            end
            pos_list[j]   = tp;
            start_list[j] = ts;
          end
          for (int i = 0; i < 2 * n; i++) begin
            send_edge(pos_list[i], start_list[i], i == 2 * n - 1);
          end
        end else begin
          // broken sweep: arbitrary length, kinds and coordinates
          len = $urandom_range(1, 20);
          for (int i = 0; i < len; i++) begin
            raw = $urandom;
            if (raw[2:0] < 3) begin
              send_edge($urandom, raw[3], i == len - 1);
            end else begin
              send_edge(pick_pos(lo_r, hi_r), raw[3], i == len - 1);
            end
          end
        end
      end
      drain();
    end

    if (sweep_model.mismatches == 0 && sweep_model.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
